// File: hdl/bsp_pkg.sv
// Shared types, constants and round functions of the 512-bit bitsliced permutation.
package bsp_pkg;

    localparam int ROUND_GROUPS    = 4;
    localparam int PASSES_PER_GRP  = 4;
    localparam int NUM_STAGES      = ROUND_GROUPS * PASSES_PER_GRP;
    localparam int NUM_WORDS       = 16;
    localparam int NUM_PAIRS       = NUM_WORDS / 2;
    localparam int WORD_W          = 32;
    localparam int PAIR_W          = 2 * WORD_W;
    localparam int ROT_W           = 5;

    typedef logic [WORD_W-1:0]                t_word;
    typedef logic [NUM_WORDS-1:0][WORD_W-1:0] t_state;

    function automatic t_word bsp_rotl(input t_word x, input logic [ROT_W-1:0] n);
        return (x << n) | (x >> (6'd32 - {1'b0, n}));
    endfunction

    // One step: column mix on each of the four lanes, then rotations of rows b, c, d.
    function automatic t_state bsp_step(input t_state s,
                                        input logic [ROT_W-1:0] rb,
                                        input logic [ROT_W-1:0] rc,
                                        input logic [ROT_W-1:0] rd);
        t_state r;
        t_word  a;
        t_word  b;
        t_word  c;
        t_word  d;
        t_word  t;
        r = s;
        for (int i = 0; i < 4; i++) begin
            a = s[i];
            b = s[4 + i];
            c = s[8 + i];
            d = s[12 + i];
            t = a;
            a = (a & b) ^ c;
            c = (b | c) ^ d;
            d = (d & a) ^ t;
            b = b ^ (c & t);
            r[i]      = a;
            r[4 + i]  = bsp_rotl(b, rb);
            r[8 + i]  = bsp_rotl(c, rc);
            r[12 + i] = bsp_rotl(d, rd);
        end
        return r;
    endfunction

    function automatic t_state bsp_pass(input t_state s);
        t_state r;
        r = bsp_step(s, 5'd1, 5'd2, 5'd3);
        r = bsp_step(r, 5'd4, 5'd8, 5'd12);
        r = bsp_step(r, 5'd8, 5'd12, 5'd16);
        return r;
    endfunction

    // Lane shuffle that closes a group: b swaps lanes 1 and 3, c swaps 0/1 and 2/3,
    // d swaps lanes 0 and 2.
    function automatic t_state bsp_shuffle(input t_state s);
        t_state r;
        r = s;
        r[5]  = s[7];
        r[7]  = s[5];
        r[8]  = s[9];
        r[9]  = s[8];
        r[10] = s[11];
        r[11] = s[10];
        r[12] = s[14];
        r[14] = s[12];
        return r;
    endfunction

endpackage

// File: hdl/bsp_stage.sv
// One pipeline stage: a full pass of three steps, optionally followed by the group shuffle.
module bsp_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_shuffle,
    input  logic            i_valid,
    input  bsp_pkg::t_state i_state,
    output logic            o_valid,
    output bsp_pkg::t_state o_state
);

    logic            r_valid;
    bsp_pkg::t_state r_state;
    bsp_pkg::t_state n_pass;
    bsp_pkg::t_state n_state;

    always_comb begin
        n_pass  = bsp_pkg::bsp_pass(i_state);
        n_state = i_shuffle ? bsp_pkg::bsp_shuffle(n_pass) : n_pass;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_valid) begin
            r_state <= n_state;
        end
    end

    assign o_valid = r_valid;
    assign o_state = r_state;

endmodule

// File: hdl/bitsliced_512bit_permutation.sv
// Top level of the 512-bit bitsliced permutation pipeline.
// The block takes one 512-bit state per cycle while the output is not stalled and delivers
// the permuted state from its last register stage: each pass of three mix-and-rotate
// steps occupies one register stage, and the lane shuffle that ends a group rides in the
// stage of that group's last pass. A stall on the output freezes the whole pipeline, so
// the input side stalls only while a finished beat waits at the output. Words 2k and 2k+1
// travel in the low and high halves of pair k on both sides.
module bitsliced_512bit_permutation (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_in_pair_0,
    input  logic [63:0] i_in_pair_1,
    input  logic [63:0] i_in_pair_2,
    input  logic [63:0] i_in_pair_3,
    input  logic [63:0] i_in_pair_4,
    input  logic [63:0] i_in_pair_5,
    input  logic [63:0] i_in_pair_6,
    input  logic [63:0] i_in_pair_7,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_out_pair_0,
    output logic [63:0] o_out_pair_1,
    output logic [63:0] o_out_pair_2,
    output logic [63:0] o_out_pair_3,
    output logic [63:0] o_out_pair_4,
    output logic [63:0] o_out_pair_5,
    output logic [63:0] o_out_pair_6,
    output logic [63:0] o_out_pair_7
);

    logic [bsp_pkg::NUM_PAIRS-1:0][bsp_pkg::PAIR_W-1:0] in_pairs;
    logic                                                pipe_en;
    logic            [bsp_pkg::NUM_STAGES:0]             stg_valid;
    bsp_pkg::t_state [bsp_pkg::NUM_STAGES:0]             stg_state;
    bsp_pkg::t_state                                     out_state;

    assign in_pairs = {i_in_pair_7, i_in_pair_6, i_in_pair_5, i_in_pair_4,
                       i_in_pair_3, i_in_pair_2, i_in_pair_1, i_in_pair_0};

    // A pair packs two adjacent words low first, so the pair vector is the state itself.
    assign stg_state[0] = bsp_pkg::t_state'(in_pairs);
    assign stg_valid[0] = i_valid;

    assign pipe_en = !(o_valid && i_stall);
    assign o_stall = !pipe_en;

    for (genvar s = 0; s < bsp_pkg::NUM_STAGES; s++) begin : g_stage
        localparam logic SHUFFLE = ((s % bsp_pkg::PASSES_PER_GRP) ==
                                    (bsp_pkg::PASSES_PER_GRP - 1));
        bsp_stage u_stage (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (pipe_en),
            .i_shuffle (SHUFFLE),
            .i_valid   (stg_valid[s]),
            .i_state   (stg_state[s]),
            .o_valid   (stg_valid[s+1]),
            .o_state   (stg_state[s+1])
        );
    end

    assign o_valid   = stg_valid[bsp_pkg::NUM_STAGES];
    assign out_state = stg_state[bsp_pkg::NUM_STAGES];

    assign o_out_pair_0 = out_state[1:0];
    assign o_out_pair_1 = out_state[3:2];
    assign o_out_pair_2 = out_state[5:4];
    assign o_out_pair_3 = out_state[7:6];
    assign o_out_pair_4 = out_state[9:8];
    assign o_out_pair_5 = out_state[11:10];
    assign o_out_pair_6 = out_state[13:12];
    assign o_out_pair_7 = out_state[15:14];

endmodule

// File: hdl/bsp_checker.sv
// Port-level checker for the permutation pipeline, bound to the top level.
module bsp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [63:0] o_out_pair_0,
    input logic [63:0] o_out_pair_1,
    input logic [63:0] o_out_pair_2,
    input logic [63:0] o_out_pair_3,
    input logic [63:0] o_out_pair_4,
    input logic [63:0] o_out_pair_5,
    input logic [63:0] o_out_pair_6,
    input logic [63:0] o_out_pair_7
);

    // A beat held at the output keeps its value until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_pair_0) && $stable(o_out_pair_1)
            && $stable(o_out_pair_2) && $stable(o_out_pair_3) && $stable(o_out_pair_4)
            && $stable(o_out_pair_5) && $stable(o_out_pair_6) && $stable(o_out_pair_7))
        else $error("output beat changed while stalled");

    // The input side backs up only when a finished beat is blocked at the output.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("input stall does not match a blocked output beat");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // With the output draining, a pipeline that is empty at the output cannot stall the input.
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled with nothing at the output");

endmodule

bind bitsliced_512bit_permutation bsp_checker u_bsp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_out_pair_0 (o_out_pair_0),
    .o_out_pair_1 (o_out_pair_1),
    .o_out_pair_2 (o_out_pair_2),
    .o_out_pair_3 (o_out_pair_3),
    .o_out_pair_4 (o_out_pair_4),
    .o_out_pair_5 (o_out_pair_5),
    .o_out_pair_6 (o_out_pair_6),
    .o_out_pair_7 (o_out_pair_7)
);

// File: tb/sv/tb_top.sv
// Self-checking testbench for the 512-bit bitsliced permutation pipeline.
module tb_top;

    typedef logic [31:0]      t_word;
    typedef logic [7:0][63:0] t_block;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 4 * bsp_pkg::NUM_STAGES;
    localparam int RANDOM_ITEMS = 900;
    localparam int CHUNK_ITEMS  = 100;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_CYCLES  = 400;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    t_block      src_data = '0;
    logic [63:0] o_out_pair_0;
    logic [63:0] o_out_pair_1;
    logic [63:0] o_out_pair_2;
    logic [63:0] o_out_pair_3;
    logic [63:0] o_out_pair_4;
    logic [63:0] o_out_pair_5;
    logic [63:0] o_out_pair_6;
    logic [63:0] o_out_pair_7;
    t_block      out_data;

    t_block pending_q[$];
    t_block expected_q[$];

    int beats_in       = 0;
    int beats_out      = 0;
    int beats_at_offer = 0;
    int src_gap        = 0;
    int src_gap_max    = 3;
    bit src_busy       = 1'b0;
    int sink_gap_max   = 3;
    int sink_wait      = 0;
    int sink_seen      = 0;
    int hold_left      = 0;
    bit hold_done      = 1'b0;
    int errors         = 0;
    int cycle_cnt      = 0;

    assign out_data = {o_out_pair_7, o_out_pair_6, o_out_pair_5, o_out_pair_4,
                       o_out_pair_3, o_out_pair_2, o_out_pair_1, o_out_pair_0};

    bitsliced_512bit_permutation uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_in_pair_0 (src_data[0]),
        .i_in_pair_1 (src_data[1]),
        .i_in_pair_2 (src_data[2]),
        .i_in_pair_3 (src_data[3]),
        .i_in_pair_4 (src_data[4]),
        .i_in_pair_5 (src_data[5]),
        .i_in_pair_6 (src_data[6]),
        .i_in_pair_7 (src_data[7]),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_pair_0(o_out_pair_0),
        .o_out_pair_1(o_out_pair_1),
        .o_out_pair_2(o_out_pair_2),
        .o_out_pair_3(o_out_pair_3),
        .o_out_pair_4(o_out_pair_4),
        .o_out_pair_5(o_out_pair_5),
        .o_out_pair_6(o_out_pair_6),
        .o_out_pair_7(o_out_pair_7)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_word rotl_word(input t_word x, input int n);
        if (n == 0)
            return x;
        return (x << n) | (x >> (32 - n));
    endfunction

    // Expected permuted state for one input beat.
    function automatic t_block permute_block(input t_block din);
        t_word  w[16];
        t_word  t;
        t_word  na;
        t_word  nb;
        t_word  nc;
        t_word  nd;
        t_word  tmp;
        int     rb;
        int     rc;
        int     rd;
        t_block dout;
        for (int k = 0; k < 8; k++) begin
            w[2 * k]     = din[k][31:0];
            w[2 * k + 1] = din[k][63:32];
        end
        for (int g = 0; g < bsp_pkg::ROUND_GROUPS; g++) begin
            for (int p = 0; p < 4; p++) begin
                for (int s = 0; s < 3; s++) begin
                    rb = (s == 0) ? 1 : (s == 1) ? 4 : 8;
                    rc = (s == 0) ? 2 : (s == 1) ? 8 : 12;
                    rd = (s == 0) ? 3 : (s == 1) ? 12 : 16;
                    for (int i = 0; i < 4; i++) begin
                        // The d update sees the new a; the b update sees the new c.
                        t  = w[i];
                        na = (w[i] & w[4 + i]) ^ w[8 + i];
                        nc = (w[4 + i] | w[8 + i]) ^ w[12 + i];
                        nd = (w[12 + i] & na) ^ t;
                        nb = w[4 + i] ^ (nc & t);
                        w[i]      = na;
                        w[4 + i]  = rotl_word(nb, rb);
                        w[8 + i]  = rotl_word(nc, rc);
                        w[12 + i] = rotl_word(nd, rd);
                    end
                end
            end
            tmp = w[5];  w[5]  = w[7];  w[7]  = tmp;
            tmp = w[8];  w[8]  = w[9];  w[9]  = tmp;
            tmp = w[10]; w[10] = w[11]; w[11] = tmp;
            tmp = w[12]; w[12] = w[14]; w[14] = tmp;
        end
        for (int k = 0; k < 8; k++)
            dout[k] = {w[2 * k + 1], w[2 * k]};
        return dout;
    endfunction

    // Sender: offers one beat at a time from pending_q, idling a drawn gap after each.
    always @(negedge i_clk) begin : driver
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (src_busy && beats_in != beats_at_offer) begin
                src_busy = 1'b0;
                src_gap  = $urandom_range(0, src_gap_max);
            end
            if (!src_busy) begin
                if (src_gap > 0) begin
                    src_gap--;
                end else if (pending_q.size() != 0) begin
                    src_data <= pending_q.pop_front();
                    src_busy       = 1'b1;
                    beats_at_offer = beats_in;
                end
            end
            i_valid <= src_busy;
        end
    end

    // Receiver: stalls a drawn number of cycles after each beat, plus one long hold.
    always @(negedge i_clk) begin : sink
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (beats_out != sink_seen) begin
                sink_seen = beats_out;
                sink_wait = $urandom_range(0, sink_gap_max);
            end else if (sink_wait > 0) begin
                sink_wait--;
            end
            if (!hold_done && beats_out >= HOLD_AT) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end else if (hold_left > 0) begin
                hold_left--;
            end
            i_stall <= (sink_wait > 0) || (hold_left > 0);
        end
    end

    // Output beats are checked before the input beat of the same edge is predicted.
    always @(posedge i_clk) begin : scoreboard
        t_block want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                beats_out <= beats_out + 1;
                if (expected_q.size() == 0) begin
                    errors++;
                    $display("%0t: result beat with no expectation, expected none, got %h",
                             $time, out_data);
                end else begin
                    want = expected_q.pop_front();
                    for (int k = 0; k < 8; k++) begin
                        if (out_data[k] !== want[k]) begin
                            errors++;
                            $display("%0t: out_pair_%0d expected %h got %h",
                                     $time, k, want[k], out_data[k]);
                        end
                    end
                end
            end
            if (i_valid && !o_stall) begin
                beats_in <= beats_in + 1;
                expected_q.push_back(permute_block(src_data));
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial begin : stimulus
        t_block blk;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        pending_q.push_back('0);
        pending_q.push_back('1);
        pending_q.push_back({8{64'hAAAA_AAAA_AAAA_AAAA}});
        pending_q.push_back({8{64'h5555_5555_5555_5555}});
        for (int k = 0; k < 8; k++) begin
            blk    = '0;
            blk[k] = '1;
            pending_q.push_back(blk);
        end
        pending_q.push_back({8{64'h0000_0000_FFFF_FFFF}});
        pending_q.push_back({8{64'hFFFF_FFFF_0000_0000}});
        for (int k = 0; k < 8; k++)
            blk[k] = {32'(2 * k + 1), 32'(2 * k)};
        pending_q.push_back(blk);
        blk    = '0;
        blk[0] = 64'h1;
        pending_q.push_back(blk);
        blk        = '0;
        blk[7][63] = 1'b1;
        pending_q.push_back(blk);
        pending_q.push_back({8{64'h8000_0000_8000_0000}});
        pending_q.push_back({8{64'h0000_0001_0000_0001}});
        blk    = '0;
        blk[0] = '1;
        blk[1] = '1;
        pending_q.push_back(blk);
        blk    = '0;
        blk[6] = '1;
        blk[7] = '1;
        pending_q.push_back(blk);

        while (pending_q.size() != 0 || src_busy || expected_q.size() != 0)
            @(posedge i_clk);

        for (int c = 0; c < RANDOM_ITEMS / CHUNK_ITEMS; c++) begin
            // Chunk 1 runs the sender flat out, so the long receiver hold fills the pipe.
            src_gap_max  = (c % 3 == 0) ? 17 : (c % 3 == 1) ? 0 : 3;
            sink_gap_max = (c % 4 == 0) ? 17 : (c % 4 == 1) ? 3 : (c % 4 == 2) ? 0 : 17;
            for (int n = 0; n < CHUNK_ITEMS; n++) begin
                for (int k = 0; k < 8; k++) begin
                    case ($urandom_range(0, 3))
                        0, 1: blk[k] = {$urandom, $urandom};
                        2: blk[k] = {$urandom, $urandom} & {$urandom, $urandom}
                                    & {$urandom, $urandom};
                        default: blk[k] = {$urandom, $urandom} | {$urandom, $urandom}
                                          | {$urandom, $urandom};
                    endcase
                end
                pending_q.push_back(blk);
            end
            if (c == 5) begin
                while (pending_q.size() != 0 || src_busy || expected_q.size() != 0)
                    @(posedge i_clk);
            end else begin
                while (pending_q.size() != 0)
                    @(posedge i_clk);
            end
        end

        while (src_busy || expected_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (expected_q.size() != 0) begin
            errors++;
            $display("%0t: %0d expected beats never arrived", $time, expected_q.size());
        end
        if (errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

// File: sim.f
hdl/bsp_pkg.sv
hdl/bsp_stage.sv
hdl/bitsliced_512bit_permutation.sv
hdl/bsp_checker.sv
tb/sv/tb_top.sv
